>>> src/itpwm_pkg.sv
// Package for the incremental PID torque-to-PWM unit.
// Shared constants, register indexes and the controller-to-datapath command type.
// No dependencies.
package itpwm_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W = 16;
    localparam int LIMIT_W = 15;
    localparam int DUTY_W = 16;
    localparam int MODE_W = 2;
    localparam int TORQUE_FRAC_BITS = 8;

    // Register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] CFG_KP_GAIN     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KI_GAIN     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KD_GAIN     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_LIMIT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOTAL_LIMIT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_PWM_PERIOD  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_GAIN   = 3'd6;

    // Reset values
    localparam logic [GAIN_W-1:0]     RST_KP_GAIN     = 16'd256;
    localparam logic [GAIN_W-1:0]     RST_KI_GAIN     = 16'd0;
    localparam logic [GAIN_W-1:0]     RST_KD_GAIN     = 16'd0;
    localparam logic [LIMIT_W-1:0]    RST_STEP_LIMIT  = 15'd256;
    localparam logic [LIMIT_W-1:0]    RST_TOTAL_LIMIT = 15'd2560;
    localparam logic [DUTY_W-1:0]     RST_PWM_PERIOD  = 16'd3600;
    localparam logic [GAIN_W-1:0]     RST_DUTY_GAIN   = 16'd256;

    // Modes
    localparam logic [MODE_W-1:0] MODE_HOLD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PID  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OPEN = 2'd2;

    // floor(x/10) == (x * DIV10_MUL) >> DIV10_SHIFT for x < 2^18
    localparam int DIV10_MUL   = 52429;
    localparam int DIV10_SHIFT = 19;
    localparam int DIV10_PROD_W = 33;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_STEP,
        OP_ACC,
        OP_MUL_DUTY,
        OP_DUTY,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        logic   load;   // latch the accepted input word
        t_dp_op op;     // datapath step for this cycle
    } t_dp_cmd;

endpackage

>>> src/itpwm_ctrl.sv
// Controller for the incremental PID torque-to-PWM unit.
// Sequences the shared multiplier and owns the output valid flag.
// Depends on itpwm_pkg.
module itpwm_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [itpwm_pkg::MODE_W-1:0]  i_mode,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output itpwm_pkg::t_dp_cmd            o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_STEP,
        S_ACC,
        S_MUL_DUTY,
        S_DUTY,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.load  = w_accept;
        o_cmd.op    = itpwm_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_mode)
                        itpwm_pkg::MODE_PID:  n_state = S_MUL_P;
                        itpwm_pkg::MODE_OPEN: n_state = S_MUL_DUTY;
                        default:              n_state = S_OUT;
                    endcase
                end
            end
            S_MUL_P: begin
                o_cmd.op = itpwm_pkg::OP_MUL_P;
                n_state  = S_MUL_I;
            end
            S_MUL_I: begin
                o_cmd.op = itpwm_pkg::OP_MUL_I;
                n_state  = S_MUL_D;
            end
            S_MUL_D: begin
                o_cmd.op = itpwm_pkg::OP_MUL_D;
                n_state  = S_STEP;
            end
            S_STEP: begin
                o_cmd.op = itpwm_pkg::OP_STEP;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = itpwm_pkg::OP_ACC;
                n_state  = S_MUL_DUTY;
            end
            S_MUL_DUTY: begin
                o_cmd.op = itpwm_pkg::OP_MUL_DUTY;
                n_state  = S_DUTY;
            end
            S_DUTY: begin
                o_cmd.op = itpwm_pkg::OP_DUTY;
                n_state  = S_OUT;
            end
            S_OUT: begin
                // wait for the output slot to drain
                if (w_out_free) begin
                    o_cmd.op    = itpwm_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> src/itpwm_dp.sv
// Datapath for the incremental PID torque-to-PWM unit.
// Config registers, error history, one shared multiplier, clamps and output word.
// Depends on itpwm_pkg.
module itpwm_dp #(
    parameter int TORQUE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  itpwm_pkg::t_dp_cmd                i_cmd,
    input  logic [itpwm_pkg::MODE_W-1:0]      i_mode,
    input  logic signed [TORQUE_WIDTH-1:0]    i_target,
    input  logic signed [TORQUE_WIDTH-1:0]    i_measured,
    input  logic                              i_cfg_we,
    input  logic [itpwm_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [itpwm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [itpwm_pkg::DUTY_W-1:0]      o_pwm_duty,
    output logic                              o_reverse_direction,
    output logic signed [TORQUE_WIDTH-1:0]    o_drive_torque
);

    localparam int TW  = TORQUE_WIDTH;
    localparam int EW  = TW + 1;                     // error
    localparam int DW  = TW + 3;                     // multiplier operand a
    localparam int GW  = itpwm_pkg::GAIN_W + 1;      // gain as signed
    localparam int PW  = DW + GW;                    // product
    localparam int SW  = PW + 2;                     // PID sum
    localparam int AW  = ((TW > 16) ? TW : 16) + 2;  // accumulator update
    localparam int OSH = itpwm_pkg::TORQUE_FRAC_BITS + GAIN_FRAC_BITS;
    localparam int QW  = PW + 1;                     // duty compare
    localparam int DUW = itpwm_pkg::DUTY_W;
    localparam int MW  = itpwm_pkg::DIV10_PROD_W;
    localparam longint TMAX_L = (longint'(1) << (TW - 1)) - 1;
    localparam logic signed [AW-1:0] TMAX = AW'(TMAX_L);

    // config registers
    logic [itpwm_pkg::GAIN_W-1:0]  r_kp, r_ki, r_kd, r_duty_gain;
    logic [itpwm_pkg::LIMIT_W-1:0] r_step_limit, r_total_limit;
    logic [DUW-1:0]                r_period;

    // item registers
    logic [itpwm_pkg::MODE_W-1:0]  r_mode;
    logic signed [TW-1:0]          r_target;
    logic signed [EW-1:0]          r_err;
    logic signed [PW-1:0]          r_prod;
    logic signed [SW-1:0]          r_sum;
    logic signed [15:0]            r_step;
    logic [DUW-1:0]                r_lo, r_hi;

    // controller state kept across items
    logic signed [EW-1:0]          r_e1, r_e2;
    logic signed [TW-1:0]          r_acc;
    logic [DUW-1:0]                r_held_duty;
    logic                          r_held_dir;

    // output word
    logic [DUW-1:0]                r_out_duty;
    logic                          r_out_dir;
    logic signed [TW-1:0]          r_out_torque;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp          <= itpwm_pkg::RST_KP_GAIN;
            r_ki          <= itpwm_pkg::RST_KI_GAIN;
            r_kd          <= itpwm_pkg::RST_KD_GAIN;
            r_step_limit  <= itpwm_pkg::RST_STEP_LIMIT;
            r_total_limit <= itpwm_pkg::RST_TOTAL_LIMIT;
            r_period      <= itpwm_pkg::RST_PWM_PERIOD;
            r_duty_gain   <= itpwm_pkg::RST_DUTY_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                itpwm_pkg::CFG_KP_GAIN:     r_kp <= i_cfg_data;
                itpwm_pkg::CFG_KI_GAIN:     r_ki <= i_cfg_data;
                itpwm_pkg::CFG_KD_GAIN:     r_kd <= i_cfg_data;
                itpwm_pkg::CFG_STEP_LIMIT:  r_step_limit <= i_cfg_data[itpwm_pkg::LIMIT_W-1:0];
                itpwm_pkg::CFG_TOTAL_LIMIT: r_total_limit <= i_cfg_data[itpwm_pkg::LIMIT_W-1:0];
                itpwm_pkg::CFG_PWM_PERIOD:  r_period <= i_cfg_data;
                itpwm_pkg::CFG_DUTY_GAIN:   r_duty_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // duty bounds: lo = floor(p/10), hi = floor(9p/10) = p - ceil(p/10)
    logic [MW-1:0] w_lo_prod, w_ceil_prod;
    assign w_lo_prod   = MW'(r_period) * MW'(itpwm_pkg::DIV10_MUL);
    assign w_ceil_prod = (MW'(r_period) + MW'(9)) * MW'(itpwm_pkg::DIV10_MUL);

    always_ff @(posedge i_clk) begin
        r_lo <= DUW'(w_lo_prod >> itpwm_pkg::DIV10_SHIFT);
        r_hi <= r_period - DUW'(w_ceil_prod >> itpwm_pkg::DIV10_SHIFT);
    end

    // shared multiplier operands
    logic signed [DW-1:0] w_op_a;
    logic signed [GW-1:0] w_op_b;
    logic signed [PW-1:0] w_prod;

    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (i_cmd.op)
            itpwm_pkg::OP_MUL_P: begin
                w_op_a = DW'(r_err) - DW'(r_e1);
                w_op_b = $signed({1'b0, r_kp});
            end
            itpwm_pkg::OP_MUL_I: begin
                w_op_a = DW'(r_err);
                w_op_b = $signed({1'b0, r_ki});
            end
            itpwm_pkg::OP_MUL_D: begin
                w_op_a = DW'(r_err) - (DW'(r_e1) <<< 1) + DW'(r_e2);
                w_op_b = $signed({1'b0, r_kd});
            end
            itpwm_pkg::OP_MUL_DUTY: begin
                if (r_mode == itpwm_pkg::MODE_PID) begin
                    w_op_a = r_acc[TW-1] ? -DW'(r_acc) : DW'(r_acc);
                end else begin
                    w_op_a = DW'(r_target);
                end
                w_op_b = $signed({1'b0, r_duty_gain});
            end
            default: ;
        endcase
    end

    assign w_prod = w_op_a * w_op_b;

    // step: floor shift, clamp to +-step_limit
    logic signed [SW-1:0] w_total, w_shift, w_slim, w_step;
    assign w_total = r_sum + SW'(r_prod);
    assign w_shift = w_total >>> GAIN_FRAC_BITS;
    assign w_slim  = $signed(SW'(r_step_limit));

    always_comb begin
        if (w_shift > w_slim)       w_step = w_slim;
        else if (w_shift < -w_slim) w_step = -w_slim;
        else                        w_step = w_shift;
    end

    // accumulator: clamp to +-total_limit, then to the torque range
    logic signed [AW-1:0] w_acc_sum, w_tlim, w_acc_c1, w_acc_c2;
    assign w_acc_sum = AW'(r_acc) + AW'(r_step);
    assign w_tlim    = $signed(AW'(r_total_limit));

    always_comb begin
        if (w_acc_sum > w_tlim)       w_acc_c1 = w_tlim;
        else if (w_acc_sum < -w_tlim) w_acc_c1 = -w_tlim;
        else                          w_acc_c1 = w_acc_sum;
        if (w_acc_c1 > TMAX)          w_acc_c2 = TMAX;
        else if (w_acc_c1 < -TMAX)    w_acc_c2 = -TMAX;
        else                          w_acc_c2 = w_acc_c1;
    end

    // duty: lo + floor(prod / 2^OSH), clamped to [lo, hi]
    logic signed [QW-1:0] w_duty_raw, w_qlo, w_qhi, w_duty;
    assign w_qlo      = $signed(QW'(r_lo));
    assign w_qhi      = $signed(QW'(r_hi));
    assign w_duty_raw = QW'(r_prod >>> OSH) + w_qlo;

    always_comb begin
        if (w_duty_raw > w_qhi)      w_duty = w_qhi;
        else if (w_duty_raw < w_qlo) w_duty = w_qlo;
        else                         w_duty = w_duty_raw;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_target <= i_target;
            r_err    <= EW'(i_target) - EW'(i_measured);
        end
        case (i_cmd.op)
            itpwm_pkg::OP_MUL_P,
            itpwm_pkg::OP_MUL_DUTY: r_prod <= w_prod;
            itpwm_pkg::OP_MUL_I: begin
                r_prod <= w_prod;
                r_sum  <= SW'(r_prod);
            end
            itpwm_pkg::OP_MUL_D: begin
                r_prod <= w_prod;
                r_sum  <= r_sum + SW'(r_prod);
            end
            itpwm_pkg::OP_STEP: r_step <= 16'(w_step);
            itpwm_pkg::OP_OUT: begin
                r_out_duty   <= r_held_duty;
                r_out_dir    <= r_held_dir;
                r_out_torque <= r_acc;
            end
            default: ;
        endcase
    end

    // state carried between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1        <= '0;
            r_e2        <= '0;
            r_acc       <= '0;
            r_held_duty <= '0;
            r_held_dir  <= 1'b0;
        end else begin
            case (i_cmd.op)
                itpwm_pkg::OP_ACC: begin
                    r_acc      <= TW'(w_acc_c2);
                    r_held_dir <= w_acc_c2[AW-1];
                    r_e2       <= r_e1;
                    r_e1       <= r_err;
                end
                itpwm_pkg::OP_DUTY: r_held_duty <= DUW'(w_duty);
                default: ;
            endcase
        end
    end

    assign o_pwm_duty          = r_out_duty;
    assign o_reverse_direction = r_out_dir;
    assign o_drive_torque      = r_out_torque;

endmodule

>>> src/incremental_pid_torque_to_pwm_unit.sv
// Top level of the incremental PID torque-to-PWM unit.
// Instantiates itpwm_ctrl and itpwm_dp; depends on itpwm_pkg.
//
// Usage
//   One motor channel. Each input word on the s_axis side is one control tick:
//   tuser carries the mode (0 hold, 1 closed-loop PID, 2 open loop, 3 = hold),
//   tdata the target and measured torque (signed, 8 fraction bits).
//   Each tick gives exactly one output word on the m_axis side: PWM compare
//   value, direction bit and the accumulated drive torque.
//   Config registers are written on the cfg port (index, 16-bit data); the
//   port is always ready. Write only while no tick is in flight.
//
// Timing
//   The multiplier is shared by P, I, D and the duty scaling, so a PID tick
//   steps through MUL_P, MUL_I, MUL_D, STEP, ACC, MUL_DUTY, DUTY and OUT, open
//   loop through MUL_DUTY, DUTY and OUT, and hold through OUT alone. The next
//   word is accepted in the cycle after the previous result is loaded into the
//   output register. A stalled output holds its word; the unit finishes the
//   next tick and waits with it until the output register frees up.
//
// Reset (synchronous, active low): history, accumulator and held duty clear
// to zero, config registers return to their defaults, no output is valid.
module incremental_pid_torque_to_pwm_unit #(
    parameter int TORQUE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [TW-1:0] target_torque, [2TW-1:TW] measured_torque, zero pad above
    input  logic [((2*TORQUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // [1:0] mode
    input  logic [itpwm_pkg::MODE_W-1:0]           s_axis_tuser,
    // output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [15:0] pwm_duty, [16] reverse_direction, [16+TW:17] drive_torque, zero pad
    output logic [((17+TORQUE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
    // config write port
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [itpwm_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [itpwm_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int TW     = TORQUE_WIDTH;
    localparam int OUT_DW = ((17 + TW + 7) / 8) * 8;
    localparam int DUW    = itpwm_pkg::DUTY_W;

    itpwm_pkg::t_dp_cmd    w_cmd;
    logic [DUW-1:0]        w_duty;
    logic                  w_dir;
    logic signed [TW-1:0]  w_torque;

    assign o_cfg_ready = 1'b1;

    itpwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    itpwm_dp #(
        .TORQUE_WIDTH   (TORQUE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_mode              (s_axis_tuser),
        .i_target            ($signed(s_axis_tdata[TW-1:0])),
        .i_measured          ($signed(s_axis_tdata[2*TW-1:TW])),
        .i_cfg_we            (i_cfg_valid),
        .i_cfg_addr          (i_cfg_addr),
        .i_cfg_data          (i_cfg_data),
        .o_pwm_duty          (w_duty),
        .o_reverse_direction (w_dir),
        .o_drive_torque      (w_torque)
    );

    // pack the output word, duty in the low bits
    assign m_axis_tdata = OUT_DW'({w_torque, w_dir, w_duty});

endmodule

>>> src/itpwm_checker.sv
// Port-level checker for the incremental PID torque-to-PWM unit, bound to the top.
// Depends on incremental_pid_torque_to_pwm_unit ports only.
module itpwm_checker #(
    parameter int TORQUE_WIDTH = 16
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((17+TORQUE_WIDTH+7)/8)*8-1:0]  m_axis_tdata
);

    localparam int DIR_BIT  = 16;
    localparam int SIGN_BIT = 16 + TORQUE_WIDTH;

    // a stalled word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    // a stalled word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // nothing valid right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");

    // direction bit always follows the sign of the drive torque
    a_dir_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[DIR_BIT] == m_axis_tdata[SIGN_BIT])
        else $error("direction disagrees with torque sign");

    // one tick at a time: input closes after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word accepted while busy");

endmodule

bind incremental_pid_torque_to_pwm_unit itpwm_checker #(
    .TORQUE_WIDTH (TORQUE_WIDTH)
) u_itpwm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/incremental_pid_torque_to_pwm_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for incremental_pid_torque_to_pwm_unit.
// Drives ticks and config writes, predicts each output word; needs itpwm_pkg and the RTL.
module incremental_pid_torque_to_pwm_unit_test;

    localparam int  TW             = 16;
    localparam int  GAIN_FRAC      = 8;
    localparam int  CYCLE_LIMIT    = 1_000_000;
    localparam int  TAIL_CYCLES    = 20;
    localparam longint TORQUE_MAX  = 32767;
    // mode 3 has no package name; the unit treats it as hold
    localparam logic [itpwm_pkg::MODE_W-1:0] MODE_HOLD_ALT = 2'd3;
    // index with no register behind it
    localparam logic [itpwm_pkg::CFG_ADDR_W-1:0] CFG_UNMAPPED = 3'd7;

    // one output word, split into its fields
    typedef struct {
        logic [itpwm_pkg::DUTY_W-1:0] duty;
        logic                         dir;
        logic [TW-1:0]                torque;
    } t_pwm_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata;                   // [15:0] target_torque, [31:16] measured_torque
    logic [itpwm_pkg::MODE_W-1:0] s_axis_tuser;  // [1:0] mode
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [15:0] duty, [16] reverse, [32:17] drive torque
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [itpwm_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [itpwm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    incremental_pid_torque_to_pwm_unit #(
        .TORQUE_WIDTH   (TW),
        .GAIN_FRAC_BITS (GAIN_FRAC)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Controller shadow: config copy and state, updated per accepted tick
    // ---------------------------------------------------------------
    logic [itpwm_pkg::GAIN_W-1:0]  kp_gain     = itpwm_pkg::RST_KP_GAIN;
    logic [itpwm_pkg::GAIN_W-1:0]  ki_gain     = itpwm_pkg::RST_KI_GAIN;
    logic [itpwm_pkg::GAIN_W-1:0]  kd_gain     = itpwm_pkg::RST_KD_GAIN;
    logic [itpwm_pkg::LIMIT_W-1:0] step_limit  = itpwm_pkg::RST_STEP_LIMIT;
    logic [itpwm_pkg::LIMIT_W-1:0] total_limit = itpwm_pkg::RST_TOTAL_LIMIT;
    logic [itpwm_pkg::DUTY_W-1:0]  pwm_period  = itpwm_pkg::RST_PWM_PERIOD;
    logic [itpwm_pkg::GAIN_W-1:0]  duty_gain   = itpwm_pkg::RST_DUTY_GAIN;

    longint                       err_last   = 0;
    longint                       err_prev   = 0;
    logic signed [TW-1:0]         drive_acc  = '0;
    logic [itpwm_pkg::DUTY_W-1:0] held_duty  = '0;
    logic                         held_dir   = 1'b0;

    t_pwm_word expected_words[$];
    int error_count    = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cycle_count    = 0;

    function automatic longint clamp_mag(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // duty = period/10 + floor(torque*gain / 2^16), kept inside [period/10, 9*period/10]
    function automatic logic [itpwm_pkg::DUTY_W-1:0] duty_for(input longint torque);
        longint p, lo, hi, d;
        p  = longint'(pwm_period);
        lo = p / 10;
        hi = (p * 9) / 10;
        d  = lo + ((torque * longint'(duty_gain))
                   >>> (itpwm_pkg::TORQUE_FRAC_BITS + GAIN_FRAC));
        if (d > hi) d = hi;
        else if (d < lo) d = lo;
        return d[itpwm_pkg::DUTY_W-1:0];
    endfunction

    // Advance the shadow controller by one tick and return the word it must produce.
    function automatic t_pwm_word predict_tick(input logic [itpwm_pkg::MODE_W-1:0] mode,
                                               input logic signed [TW-1:0] target,
                                               input logic signed [TW-1:0] measured);
        longint err, d1, d2, sum, step_delta, acc_next;
        t_pwm_word w;
        if (mode == itpwm_pkg::MODE_PID) begin
            err  = longint'(target) - longint'(measured);
            d1   = err - err_last;
            d2   = err - 2 * err_last + err_prev;
            sum  = longint'(kp_gain) * d1 + longint'(ki_gain) * err
                 + longint'(kd_gain) * d2;
            step_delta = clamp_mag(sum >>> GAIN_FRAC, longint'(step_limit));
            acc_next   = clamp_mag(longint'(drive_acc) + step_delta, longint'(total_limit));
            acc_next   = clamp_mag(acc_next, TORQUE_MAX);
            drive_acc  = acc_next[TW-1:0];
            held_duty  = duty_for(acc_next < 0 ? -acc_next : acc_next);
            held_dir   = (acc_next < 0);
            err_prev   = err_last;
            err_last   = err;
        end else if (mode == itpwm_pkg::MODE_OPEN) begin
            // open loop: signed target, direction and history untouched
            held_duty = duty_for(longint'(target));
        end
        w.duty   = held_duty;
        w.dir    = held_dir;
        w.torque = drive_acc;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Output side: random backpressure at negedge, checks at posedge
    // ---------------------------------------------------------------
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge i_clk) begin : check_words
        t_pwm_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("word with none expected", longint'(m_axis_tdata), 0);
            end else begin
                want = expected_words.pop_front();
                if (m_axis_tdata[15:0] !== want.duty)
                    report_mismatch("pwm_duty", m_axis_tdata[15:0], want.duty);
                if (m_axis_tdata[16] !== want.dir)
                    report_mismatch("reverse_direction", m_axis_tdata[16], want.dir);
                if (m_axis_tdata[32:17] !== want.torque)
                    report_mismatch("drive_torque", $signed(m_axis_tdata[32:17]),
                                    $signed(want.torque));
            end
        end
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("incremental_pid_torque_to_pwm_unit_test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Input side helpers
    // ---------------------------------------------------------------

    // Offer one tick word; valid stays high after acceptance so back-to-back
    // words need no low cycle. Random idle cycles come first.
    task automatic send_tick(input logic [itpwm_pkg::MODE_W-1:0] mode,
                             input logic [TW-1:0] target,
                             input logic [TW-1:0] measured);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {measured, target};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_words.push_back(predict_tick(mode, target, measured));
    endtask

    // Drop valid and wait for every outstanding word; unit is idle after this.
    task automatic drain_words;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // Single config write; only called while the unit is idle.
    task automatic write_reg(input logic [itpwm_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [itpwm_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            itpwm_pkg::CFG_KP_GAIN:     kp_gain     = val;
            itpwm_pkg::CFG_KI_GAIN:     ki_gain     = val;
            itpwm_pkg::CFG_KD_GAIN:     kd_gain     = val;
            itpwm_pkg::CFG_STEP_LIMIT:  step_limit  = val[itpwm_pkg::LIMIT_W-1:0];
            itpwm_pkg::CFG_TOTAL_LIMIT: total_limit = val[itpwm_pkg::LIMIT_W-1:0];
            itpwm_pkg::CFG_PWM_PERIOD:  pwm_period  = val;
            itpwm_pkg::CFG_DUTY_GAIN:   duty_gain   = val;
            default: ;  // unmapped index, ignored
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [itpwm_pkg::CFG_DATA_W-1:0] pick_setting();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return itpwm_pkg::CFG_DATA_W'($urandom_range(0, 511));
            3: return itpwm_pkg::CFG_DATA_W'($urandom_range(0, 4095));
            default: return itpwm_pkg::CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic load_random_settings;
        write_reg(itpwm_pkg::CFG_KP_GAIN,     pick_setting());
        write_reg(itpwm_pkg::CFG_KI_GAIN,     pick_setting());
        write_reg(itpwm_pkg::CFG_KD_GAIN,     pick_setting());
        write_reg(itpwm_pkg::CFG_STEP_LIMIT,  pick_setting());
        write_reg(itpwm_pkg::CFG_TOTAL_LIMIT, pick_setting());
        // zero period now and then, otherwise a usable one
        write_reg(itpwm_pkg::CFG_PWM_PERIOD,
                  ($urandom_range(7) == 0) ? pick_setting()
                      : itpwm_pkg::CFG_DATA_W'($urandom_range(1, 65535)));
        write_reg(itpwm_pkg::CFG_DUTY_GAIN,   pick_setting());
    endtask

    function automatic logic [TW-1:0] pick_torque(input logic [TW-1:0] center);
        case ($urandom_range(9))
            0, 1: return TW'($urandom);
            2: begin
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return TW'(center + $urandom_range(0, 2047) - 16'd1024);
        endcase
    endfunction

    // Mostly closed-loop runs around a wandering setpoint; open loop,
    // hold and the alias hold mode sprinkled in.
    task automatic send_random_tick(inout logic [TW-1:0] setpoint);
        logic [itpwm_pkg::MODE_W-1:0] mode;
        int pick;
        pick = $urandom_range(99);
        if (pick < 58)      mode = itpwm_pkg::MODE_PID;
        else if (pick < 78) mode = itpwm_pkg::MODE_OPEN;
        else if (pick < 92) mode = itpwm_pkg::MODE_HOLD;
        else                mode = MODE_HOLD_ALT;
        if ($urandom_range(15) == 0) setpoint = TW'($urandom);
        send_tick(mode, pick_torque(setpoint), pick_torque(setpoint));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // hold before any update gives zero duty and direction
    task automatic test_hold_after_reset;
        send_tick(itpwm_pkg::MODE_HOLD, 16'h0000, 16'h0000);
        send_tick(MODE_HOLD_ALT, 16'h8000, 16'h7FFF);
        drain_words();
    endtask

    // closed loop at the error extremes, all three gains active
    task automatic test_pid_extremes;
        write_reg(itpwm_pkg::CFG_KI_GAIN, 16'd128);
        write_reg(itpwm_pkg::CFG_KD_GAIN, 16'd64);
        send_tick(itpwm_pkg::MODE_PID, 16'h7FFF, 16'h8000);
        send_tick(itpwm_pkg::MODE_PID, 16'h8000, 16'h7FFF);
        send_tick(itpwm_pkg::MODE_PID, 16'h8000, 16'h7FFF);
        send_tick(itpwm_pkg::MODE_PID, 16'h0000, 16'h0000);
        send_tick(itpwm_pkg::MODE_HOLD, 16'h1234, 16'h4321);
        drain_words();
    endtask

    // open loop keeps direction and accumulator; negative target sits at 10%
    task automatic test_open_loop;
        send_tick(itpwm_pkg::MODE_OPEN, 16'h7FFF, 16'h0000);
        send_tick(itpwm_pkg::MODE_OPEN, 16'h8000, 16'h7FFF);
        send_tick(itpwm_pkg::MODE_OPEN, 16'h0000, 16'h8000);
        send_tick(MODE_HOLD_ALT, 16'h7FFF, 16'h7FFF);
        drain_words();
    endtask

    // accumulator reaching the total limit, then reclamped after lowering it;
    // zero period and an unmapped index
    task automatic test_limits_and_period;
        write_reg(itpwm_pkg::CFG_KP_GAIN, 16'd256);
        write_reg(itpwm_pkg::CFG_KI_GAIN, 16'd0);
        write_reg(itpwm_pkg::CFG_KD_GAIN, 16'd0);
        write_reg(itpwm_pkg::CFG_STEP_LIMIT, 16'd256);
        write_reg(itpwm_pkg::CFG_TOTAL_LIMIT, 16'd512);
        send_tick(itpwm_pkg::MODE_PID, 16'h4000, 16'h0000);
        send_tick(itpwm_pkg::MODE_PID, 16'h7FFF, 16'h0000);
        send_tick(itpwm_pkg::MODE_PID, 16'h7FFF, 16'h0000);
        drain_words();
        write_reg(itpwm_pkg::CFG_TOTAL_LIMIT, 16'd100);
        write_reg(itpwm_pkg::CFG_KP_GAIN, 16'd0);
        send_tick(itpwm_pkg::MODE_PID, 16'h0100, 16'h0000);
        drain_words();
        write_reg(itpwm_pkg::CFG_PWM_PERIOD, 16'd0);
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        send_tick(itpwm_pkg::MODE_OPEN, 16'h7FFF, 16'h0000);
        send_tick(itpwm_pkg::MODE_PID, 16'h0100, 16'h0000);
        drain_words();
    endtask

    // every register at its top value, bit 15 of the limits masked off
    task automatic test_gain_extremes;
        write_reg(itpwm_pkg::CFG_KP_GAIN, 16'hFFFF);
        write_reg(itpwm_pkg::CFG_KI_GAIN, 16'hFFFF);
        write_reg(itpwm_pkg::CFG_KD_GAIN, 16'hFFFF);
        write_reg(itpwm_pkg::CFG_STEP_LIMIT, 16'hFFFF);
        write_reg(itpwm_pkg::CFG_TOTAL_LIMIT, 16'hFFFF);
        write_reg(itpwm_pkg::CFG_PWM_PERIOD, 16'hFFFF);
        write_reg(itpwm_pkg::CFG_DUTY_GAIN, 16'hFFFF);
        send_tick(itpwm_pkg::MODE_PID, 16'h8000, 16'h7FFF);
        send_tick(itpwm_pkg::MODE_PID, 16'h7FFF, 16'h8000);
        send_tick(itpwm_pkg::MODE_OPEN, 16'h7FFF, 16'h8000);
        drain_words();
    endtask

    // Random traffic under one idling pattern, three settings per phase.
    // Early on the sender stops until every word is back.
    task automatic test_random_phase(input int src_pct, input int sink_pct, input int n_items);
        logic [TW-1:0] setpoint;
        setpoint = TW'($urandom);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int blk = 0; blk < 3; blk++) begin
            load_random_settings();
            for (int n = 0; n < n_items / 3; n++) begin
                if (blk == 0 && n == n_items / 6) begin
                    @(negedge i_clk);
                    s_axis_tvalid <= 1'b0;
                    while (expected_words.size() != 0) @(posedge i_clk);
                end
                send_random_tick(setpoint);
            end
            drain_words();
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = itpwm_pkg::MODE_HOLD;
        i_cfg_valid   = 1'b0;
        i_cfg_addr    = itpwm_pkg::CFG_KP_GAIN;
        i_cfg_data    = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_hold_after_reset();
        test_pid_extremes();
        test_open_loop();
        test_limits_and_period();
        test_gain_extremes();

        test_random_phase(0, 0, 450);
        test_random_phase(73, 0, 450);
        test_random_phase(0, 73, 450);
        test_random_phase(8, 8, 450);

        drain_words();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // catch any stray word after the last expected one
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("incremental_pid_torque_to_pwm_unit_test passed");
        else
            $display("incremental_pid_torque_to_pwm_unit_test failed");
        $finish;
    end

endmodule
